// ----- src/bnq_pkg.sv -----
// ----------------------------------------------------------------------------
// bnq_pkg
// Shared types and constants for the bounded notification queue: channel
// words, configuration register indexes and the controller/datapath links.
// ----------------------------------------------------------------------------
package bnq_pkg;

  // operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_TRIM  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_QUEUE_SIZE     = 2'd0;
  localparam logic [1:0] CFG_DISCARD_OLDEST = 2'd1;
  localparam logic [1:0] CFG_EVENT_MODE     = 2'd2;

  localparam int QSZ_W   = 6;
  localparam int CFG_W   = 6;
  localparam int CNT_OUT = 7;

  // input word
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] payload;
    logic [31:0] status;
  } bnq_in_t;

  // result word
  typedef struct packed {
    logic         ok;
    logic [31:0]  payload_out;
    logic [31:0]  status_out;
    logic         is_overflow_marker;
    logic         more_left;
    logic [6:0]   entry_count;
  } bnq_out_t;

  // one ring entry
  typedef struct packed {
    logic [31:0] payload;
    logic [31:0] status;
    logic        marker;
  } bnq_entry_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;
    logic fail;
    logic rd_en;
    logic rd_tail;
    logic discard;
    logic wr_back;
    logic marker_front;
    logic marker_back;
    logic mark_wr;
    logic pop;
    logic clear;
    logic set_seen;
    logic res_out;
  } bnq_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       event_mode;
    logic       discard_oldest;
    logic       sz_zero;
    logic       sz_one;
    logic       cnt_zero;
    logic       cnt_lt_sz;
    logic       cnt_gt_sz;
    logic       seen;
    logic       rd_marker;
    logic       out_free;
  } bnq_stat_t;

endpackage

// ----- src/bounded_notification_queue.sv -----
// ----------------------------------------------------------------------------
// bounded_notification_queue
// Ring queue of notification entries with discard-on-overflow policies.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carries one operation word (push, pop, clear,
//   trim); out_valid/out_stall/out_data returns exactly one result word per
//   operation. cfg_we/cfg_index/cfg_data writes queue_size, discard_oldest
//   and event_mode; write them only while no operation is in flight.
//   Each operation is worked as a sequence of steps: every discard, insert
//   and status update is its own step. The ring memory has one write port
//   and a registered read port, so the overflow status mark is a read step
//   followed by a write step.
//   One operation is worked at a time; in_stall is high from acceptance
//   until the result is loaded into the output register.
//   Reset empties the queue, clears the overflow history and loads
//   queue_size=1, discard_oldest=1, event_mode=0. Ring contents are not
//   cleared. A stalled result holds in the output register; the next
//   operation is taken meanwhile and waits only for its own result slot.
// ----------------------------------------------------------------------------
module bounded_notification_queue import bnq_pkg::*; #(
  parameter int          MAX_SIZE      = 63,
  parameter logic [31:0] OVERFLOW_MASK = 32'd1152
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bnq_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output bnq_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  bnq_cmd_t  cmd;
  bnq_stat_t st;

  // sequencer
  bnq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // ring datapath
  bnq_dp #(
    .MAX_SIZE      (MAX_SIZE),
    .OVERFLOW_MASK (OVERFLOW_MASK)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ----- src/bnq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bnq_ctrl
// Sequencer: walks one operation through discard, read, insert and
// overflow-mark steps on the ring datapath.
// ----------------------------------------------------------------------------
module bnq_ctrl import bnq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bnq_stat_t st,
  output bnq_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_DISC, S_WRITE, S_MARK_RD, S_MARK_WR, S_POP_RD,
    S_POP_CAP, S_EV_CHK, S_EV_RD, S_EV_DISC, S_EV_MARK, S_RESULT
  } state_t;

  state_t     state_r, state_nxt;
  logic       dropped_r, dropped_nxt;
  logic       have_r, have_nxt;
  logic       got_r, got_nxt;
  logic [1:0] tries_r, tries_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    dropped_nxt = dropped_r;
    have_nxt    = have_r;
    got_nxt     = got_r;
    tries_nxt   = tries_r;
    cmd         = '0;
    cmd.rd_tail = !st.discard_oldest;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          dropped_nxt = 1'b0;
          have_nxt    = 1'b0;
          got_nxt     = 1'b0;
          tries_nxt   = 2'd0;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (st.op)
          OP_PUSH: begin
            if (st.event_mode && st.cnt_lt_sz) begin
              state_nxt = S_WRITE;
            end else if (st.sz_zero) begin
              cmd.fail  = 1'b1;
              state_nxt = S_RESULT;
            end else if (st.event_mode) begin
              state_nxt = S_EV_CHK;
            end else if (!st.cnt_lt_sz) begin
              state_nxt = S_DISC;
            end else begin
              state_nxt = S_WRITE;
            end
          end
          OP_POP: begin
            if (st.cnt_zero) begin
              cmd.fail  = 1'b1;
              state_nxt = S_RESULT;
            end else begin
              state_nxt = S_POP_RD;
            end
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = S_RESULT;
          end
          default: state_nxt = S_DISC;
        endcase
      end
      // one discard per cycle until the count fits
      S_DISC: begin
        if (st.op == OP_PUSH) begin
          if (!st.cnt_lt_sz) begin
            cmd.discard = 1'b1;
            dropped_nxt = 1'b1;
          end else begin
            state_nxt = S_WRITE;
          end
        end else if (st.cnt_gt_sz) begin
          cmd.discard = 1'b1;
          dropped_nxt = 1'b1;
        end else if (dropped_r && !st.sz_zero && !st.sz_one && !st.event_mode) begin
          state_nxt = S_MARK_RD;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_WRITE: begin
        cmd.wr_back = 1'b1;
        if (!st.event_mode && dropped_r && !st.sz_one) state_nxt = S_MARK_RD;
        else state_nxt = S_RESULT;
      end
      // read-modify-write of the new head or tail status
      S_MARK_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_POP_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_tail = 1'b0;
        state_nxt   = S_POP_CAP;
      end
      S_POP_CAP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_RESULT;
      end
      // event mode: up to two discards, skipping the marker
      S_EV_CHK: begin
        if (!got_r && tries_r < 2'd2 && !st.cnt_zero) state_nxt = S_EV_RD;
        else state_nxt = S_EV_MARK;
      end
      S_EV_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EV_DISC;
      end
      S_EV_DISC: begin
        cmd.discard = 1'b1;
        if (st.rd_marker) have_nxt = 1'b1;
        else got_nxt = 1'b1;
        tries_nxt = tries_r + 2'd1;
        state_nxt = S_EV_CHK;
      end
      S_EV_MARK: begin
        if (!st.seen) begin
          cmd.set_seen = 1'b1;
          if (st.discard_oldest) cmd.marker_front = 1'b1;
          else cmd.marker_back = 1'b1;
        end else if (have_r) begin
          cmd.marker_front = 1'b1;
        end
        state_nxt = S_WRITE;
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.res_out = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and loop flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      dropped_r <= 1'b0;
      have_r    <= 1'b0;
      got_r     <= 1'b0;
      tries_r   <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
      have_r    <= have_nxt;
      got_r     <= got_nxt;
      tries_r   <= tries_nxt;
    end
  end

endmodule

// ----- src/bnq_dp.sv -----
// ----------------------------------------------------------------------------
// bnq_dp
// Datapath: ring memory, head and count registers, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
module bnq_dp import bnq_pkg::*; #(
  parameter int          MAX_SIZE      = 63,
  parameter logic [31:0] OVERFLOW_MASK = 32'd1152
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bnq_in_t          in_data,
  input  logic             out_stall,
  output logic             out_valid,
  output bnq_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  bnq_cmd_t         cmd,
  output bnq_stat_t        st
);

  localparam int DEPTH = MAX_SIZE + 1;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;
  localparam int KW    = (CW > QSZ_W) ? CW : QSZ_W;
  localparam int EW    = (CW > CNT_OUT) ? CW : CNT_OUT;

  bnq_entry_t mem [DEPTH];

  logic [IW-1:0]    head_r;
  logic [CW-1:0]    count_r;
  logic             seen_r;
  logic [QSZ_W-1:0] qsize_r;
  logic             disc_old_r;
  logic             evt_r;
  logic [1:0]       op_r;
  logic [31:0]      pay_r;
  logic [31:0]      stat_r;
  logic             ok_r;
  logic [31:0]      po_r;
  logic [31:0]      so_r;
  logic             mo_r;
  logic [IW-1:0]    rd_addr_r;
  bnq_entry_t       rd_q_r;
  logic             out_valid_r;
  bnq_out_t         out_r;

  logic [KW-1:0] sz, cnt_k, qs_k;
  logic [SW-1:0] sum_back, sum_tail;
  logic [IW-1:0] back_slot, tail_slot, front_slot, head_inc, rd_addr;
  logic          full;
  logic          we;
  logic [IW-1:0] wa;
  bnq_entry_t    wd;
  logic [EW-1:0] cnt_e;

  // effective size: register clamped to the ring capacity
  assign qs_k  = KW'(qsize_r);
  assign cnt_k = KW'(count_r);
  assign sz    = (qs_k > KW'(MAX_SIZE)) ? KW'(MAX_SIZE) : qs_k;

  // ring slot arithmetic
  assign sum_back   = SW'(head_r) + SW'(count_r);
  assign back_slot  = (sum_back >= SW'(DEPTH)) ? IW'(sum_back - SW'(DEPTH)) : IW'(sum_back);
  assign sum_tail   = sum_back - SW'(1);
  assign tail_slot  = (sum_tail >= SW'(DEPTH)) ? IW'(sum_tail - SW'(DEPTH)) : IW'(sum_tail);
  assign front_slot = (head_r == '0) ? IW'(MAX_SIZE) : head_r - IW'(1);
  assign head_inc   = (head_r == IW'(MAX_SIZE)) ? '0 : head_r + IW'(1);
  assign full       = (count_r >= CW'(DEPTH));
  assign rd_addr    = cmd.rd_tail ? tail_slot : head_r;

  // status to the controller
  always_comb begin
    st                = '0;
    st.op             = op_r;
    st.event_mode     = evt_r;
    st.discard_oldest = disc_old_r;
    st.sz_zero        = (sz == '0);
    st.sz_one         = (sz == KW'(1));
    st.cnt_zero       = (count_r == '0);
    st.cnt_lt_sz      = (cnt_k < sz);
    st.cnt_gt_sz      = (cnt_k > sz);
    st.seen           = seen_r;
    st.rd_marker      = rd_q_r.marker;
    st.out_free       = !out_valid_r || !out_stall;
  end

  // memory write port selection
  always_comb begin
    we = 1'b0;
    wa = back_slot;
    wd = '{payload: pay_r, status: stat_r, marker: 1'b0};
    if (cmd.wr_back) begin
      we = !full;
    end else if (cmd.marker_back) begin
      we = !full;
      wd = '{payload: '0, status: '0, marker: 1'b1};
    end else if (cmd.marker_front) begin
      we = !full;
      wa = front_slot;
      wd = '{payload: '0, status: '0, marker: 1'b1};
    end else if (cmd.mark_wr) begin
      we = 1'b1;
      wa = rd_addr_r;
      wd = rd_q_r;
      wd.status = rd_q_r.status | OVERFLOW_MASK;
    end
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // operation word and popped fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.operation;
      pay_r  <= in_data.payload;
      stat_r <= in_data.status;
      ok_r   <= 1'b1;
      po_r   <= '0;
      so_r   <= '0;
      mo_r   <= 1'b0;
    end else if (cmd.fail) begin
      ok_r <= 1'b0;
    end else if (cmd.pop) begin
      po_r <= rd_q_r.payload;
      so_r <= rd_q_r.status;
      mo_r <= rd_q_r.marker;
    end
  end

  // head, count, overflow flag and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      count_r    <= '0;
      seen_r     <= 1'b0;
      qsize_r    <= QSZ_W'(1);
      disc_old_r <= 1'b1;
      evt_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUEUE_SIZE:     qsize_r    <= cfg_data[QSZ_W-1:0];
          CFG_DISCARD_OLDEST: disc_old_r <= cfg_data[0];
          CFG_EVENT_MODE:     evt_r      <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.set_seen) seen_r <= 1'b1;
      if (cmd.clear) begin
        head_r  <= '0;
        count_r <= '0;
      end else if (cmd.discard) begin
        if (disc_old_r) head_r <= head_inc;
        count_r <= count_r - CW'(1);
      end else if (cmd.pop) begin
        head_r  <= head_inc;
        count_r <= count_r - CW'(1);
      end else if ((cmd.wr_back || cmd.marker_back) && !full) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.marker_front && !full) begin
        head_r  <= front_slot;
        count_r <= count_r + CW'(1);
      end
    end
  end

  assign cnt_e = EW'(count_r);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_out) begin
      out_r.ok                 <= ok_r;
      out_r.payload_out        <= po_r;
      out_r.status_out         <= so_r;
      out_r.is_overflow_marker <= mo_r;
      out_r.more_left          <= (count_r != '0);
      out_r.entry_count        <= cnt_e[CNT_OUT-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/bnq_chk.sv -----
// ----------------------------------------------------------------------------
// bnq_chk
// Port-level checks on the notification queue, bound to the top level.
// ----------------------------------------------------------------------------
module bnq_chk import bnq_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input bnq_out_t out_data
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");

  // one operation at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  // more_left agrees with the count
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.more_left == (out_data.entry_count != 7'd0)))
    else $error("more_left disagrees with entry_count");

  // a failed operation returns no entry
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> (out_data.payload_out == 32'd0) &&
      (out_data.status_out == 32'd0) && !out_data.is_overflow_marker)
    else $error("failed operation returned entry data");

  // reset empties the result channel
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bounded_notification_queue bnq_chk u_bnq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
